// File: rtl/fixed_object_pool_allocator_macros.svh
// Assertion macros shared by the RTL. Each expects clk and rst_n in scope.
`ifndef FIXED_OBJECT_POOL_ALLOCATOR_MACROS_SVH
`define FIXED_OBJECT_POOL_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

`define FOPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fopa: implication check failed");

`define FOPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fopa: next-cycle check failed");

`else

`define FOPA_ASSERT_IMP(lbl, ante, cons)

`define FOPA_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/fopa_pkg.sv
`default_nettype none

package fopa_pkg;

  localparam int POOL_DEPTH = 64;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    logic             clr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] wdata;
    logic [IDX_W-1:0] raddr;
  } stk_req_t;

  typedef struct packed {
    logic             clr;
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic             wdata;
    logic [IDX_W-1:0] raddr;
  } mark_req_t;

endpackage

`default_nettype wire

// File: rtl/fixed_object_pool_allocator.sv
// A request taken while busy is low is worked on in the busy state, and its result is
// registered onto the out_ ports, marked by out_valid; the receiver cannot stall. A new
// request is not taken while busy is high, set by the read-modify-write of the stack and
// mark memories, whose reads are registered. Reset is synchronous, active low: the pool
// holds 64 free objects, highest index first; a configuration beat rebuilds it at once.
`default_nettype none
`include "fixed_object_pool_allocator_macros.svh"

module fixed_object_pool_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic                       in_op,
  input  logic [fopa_pkg::IDX_W-1:0] in_object_index,
  output logic                       out_valid,
  output logic [1:0]                 out_status,
  output logic [fopa_pkg::IDX_W-1:0] out_granted_index,
  output logic [fopa_pkg::CNT_W-1:0] out_free_objects,
  output logic [fopa_pkg::CNT_W-1:0] out_used_objects,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [fopa_pkg::CNT_W-1:0] cfg_object_count
);
  import fopa_pkg::*;

  localparam logic [CNT_W-1:0] FULL = CNT_W'(POOL_DEPTH);

  logic             busy_r;
  op_t              op_r;
  logic [IDX_W-1:0] idx_r;
  logic [CNT_W-1:0] depth_r, depth_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r;
  status_t          status_r, status_nxt;
  logic [IDX_W-1:0] grant_r, grant_nxt;
  logic [CNT_W-1:0] free_r;
  logic [CNT_W-1:0] used_r;

  logic             accept;
  logic             cfg_wr;
  logic [CNT_W-1:0] cfg_cap;
  stk_req_t         stk_req;
  mark_req_t        mark_req;
  logic [IDX_W-1:0] stk_rdata;
  logic             mark_rdata;

  fopa_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (stk_req),
    .rdata (stk_rdata)
  );

  fopa_mark u_mark (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mark_req),
    .rdata (mark_rdata)
  );

  assign accept    = start && !busy_r;
  assign cfg_ready = !busy_r;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign cfg_cap   = (cfg_object_count > FULL) ? FULL : cfg_object_count;

  always_comb begin
    depth_nxt      = depth_r;
    count_nxt      = count_r;
    status_nxt     = ST_OK;
    grant_nxt      = '0;
    stk_req        = '0;
    mark_req       = '0;
    stk_req.raddr  = IDX_W'(depth_r - CNT_W'(1));
    mark_req.raddr = in_object_index;
    if (busy_r) begin
      case (op_r)
        OP_ALLOC: begin
          if (depth_r == '0) begin
            status_nxt = ST_EMPTY;
          end else begin
            depth_nxt      = depth_r - CNT_W'(1);
            grant_nxt      = stk_rdata;
            mark_req.we    = 1'b1;
            mark_req.waddr = stk_rdata;
            mark_req.wdata = 1'b1;
          end
        end
        OP_FREE: begin
          if ({1'b0, idx_r} >= count_r || !mark_rdata || depth_r >= FULL) begin
            status_nxt = ST_BADFREE;
          end else begin
            depth_nxt      = depth_r + CNT_W'(1);
            mark_req.we    = 1'b1;
            mark_req.waddr = idx_r;
            mark_req.wdata = 1'b0;
            stk_req.we     = 1'b1;
            stk_req.waddr  = depth_r[IDX_W-1:0];
            stk_req.wdata  = idx_r;
          end
        end
        default: status_nxt = ST_BADFREE;
      endcase
    end else if (cfg_wr) begin
      count_nxt    = cfg_cap;
      depth_nxt    = cfg_cap;
      stk_req.clr  = 1'b1;
      mark_req.clr = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      depth_r     <= FULL;
      count_r     <= FULL;
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
      depth_r     <= depth_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r  <= op_t'(in_op);
      idx_r <= in_object_index;
    end
    if (busy_r) begin
      status_r <= status_nxt;
      grant_r  <= grant_nxt;
      free_r   <= depth_nxt;
      used_r   <= count_r - depth_nxt;
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_status        = status_r;
  assign out_granted_index = grant_r;
  assign out_free_objects  = free_r;
  assign out_used_objects  = used_r;

  `FOPA_ASSERT_NEXT(a_accept_busy, accept, busy_r)
  `FOPA_ASSERT_NEXT(a_busy_single, busy_r, !busy_r && out_valid_r)
  `FOPA_ASSERT_IMP(a_depth_bound, 1'b1, depth_r <= count_r && count_r <= FULL)
  `FOPA_ASSERT_IMP(a_fail_no_grant, out_valid_r && status_r != ST_OK, grant_r == '0)
  `FOPA_ASSERT_IMP(a_counts_sum, out_valid_r, free_r + used_r == count_r)

endmodule

`default_nettype wire

// File: rtl/fopa_stack.sv
`default_nettype none

module fopa_stack (
  input  logic                       clk,
  input  logic                       rst_n,
  input  fopa_pkg::stk_req_t         req,
  output logic [fopa_pkg::IDX_W-1:0] rdata
);
  import fopa_pkg::*;

  logic [IDX_W-1:0]      mem [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] vld_r;
  logic [IDX_W-1:0]      rd_r;
  logic [IDX_W-1:0]      raddr_r;
  logic                  rvld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_r    <= mem[req.raddr];
    raddr_r <= req.raddr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
      rvld_r <= vld_r[req.raddr];
    end
  end

  // A slot never written since the last rebuild holds its own index.
  assign rdata = rvld_r ? rd_r : raddr_r;

endmodule

`default_nettype wire

// File: rtl/fopa_mark.sv
`default_nettype none

module fopa_mark (
  input  logic                clk,
  input  logic                rst_n,
  input  fopa_pkg::mark_req_t req,
  output logic                rdata
);
  import fopa_pkg::*;

  logic                  mem [POOL_DEPTH];
  logic [POOL_DEPTH-1:0] vld_r;
  logic                  rd_r;
  logic                  rvld_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_r <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || req.clr) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (req.we) begin
        vld_r[req.waddr] <= 1'b1;
      end
      rvld_r <= vld_r[req.raddr];
    end
  end

  assign rdata = rvld_r & rd_r;

endmodule

`default_nettype wire

// File: tb/sv/fixed_object_pool_allocator_test.sv
`timescale 1ns / 1ps

module fixed_object_pool_allocator_test;
  import fopa_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    status_t          status;
    logic [IDX_W-1:0] granted;
    logic [CNT_W-1:0] free_n;
    logic [CNT_W-1:0] used_n;
  } pool_answer_t;

  class pool_scoreboard;
    int               pool_size;
    int               stack_depth;
    logic [IDX_W-1:0] free_stack [POOL_DEPTH];
    bit               held [POOL_DEPTH];
    pool_answer_t     pending_answers [$];
    int               mismatches;
    int               requests;
    int               grants;
    int               empties;
    int               rejects;

    function new();
      rebuild(7'd64);
    endfunction

    function void rebuild(logic [CNT_W-1:0] value);
      pool_size = (int'(value) > POOL_DEPTH) ? POOL_DEPTH : int'(value);
      for (int k = 0; k < POOL_DEPTH; k++) begin
        free_stack[k] = IDX_W'(k);
        held[k] = 1'b0;
      end
      stack_depth = pool_size;
    endfunction

    function int pick_held();
      int candidates [$];
      foreach (held[k]) if (held[k]) candidates.push_back(k);
      if (candidates.size() == 0) return -1;
      return candidates[$urandom_range(0, candidates.size() - 1)];
    endfunction

    function void note_request(op_t op, logic [IDX_W-1:0] idx);
      pool_answer_t a;
      a.status = ST_OK;
      a.granted = '0;
      if (op == OP_ALLOC) begin
        if (stack_depth == 0 || stack_depth > POOL_DEPTH) begin
          a.status = ST_EMPTY;
        end else begin
          stack_depth--;
          a.granted = free_stack[stack_depth];
          held[a.granted] = 1'b1;
        end
      end else begin
        if (int'(idx) >= pool_size || !held[idx] || stack_depth >= POOL_DEPTH) begin
          a.status = ST_BADFREE;
        end else begin
          held[idx] = 1'b0;
          free_stack[stack_depth] = idx;
          stack_depth++;
        end
      end
      a.free_n = CNT_W'(stack_depth);
      a.used_n = CNT_W'(pool_size - stack_depth);
      requests++;
      case (a.status)
        ST_OK:    if (op == OP_ALLOC) grants++;
        ST_EMPTY: empties++;
        default:  rejects++;
      endcase
      pending_answers.push_back(a);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(logic [1:0] status, logic [IDX_W-1:0] granted,
                      logic [CNT_W-1:0] free_n, logic [CNT_W-1:0] used_n);
      pool_answer_t a;
      if (pending_answers.size() == 0) begin
        report_mismatch("result beat with nothing pending, status", status, 0);
      end else begin
        a = pending_answers.pop_front();
        if (status !== a.status) report_mismatch("status", status, a.status);
        if (granted !== a.granted) report_mismatch("granted index", granted, a.granted);
        if (free_n !== a.free_n) report_mismatch("free count", free_n, a.free_n);
        if (used_n !== a.used_n) report_mismatch("used count", used_n, a.used_n);
      end
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic             in_op = 1'b0;
  logic [IDX_W-1:0] in_object_index = '0;
  logic             out_valid;
  logic [1:0]       out_status;
  logic [IDX_W-1:0] out_granted_index;
  logic [CNT_W-1:0] out_free_objects;
  logic [CNT_W-1:0] out_used_objects;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_object_count = '0;

  pool_scoreboard sb;
  int             cycles = 0;
  int             sizes_tried = 0;

  fixed_object_pool_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_object_index   (in_object_index),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_granted_index (out_granted_index),
    .out_free_objects  (out_free_objects),
    .out_used_objects  (out_used_objects),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_object_count  (cfg_object_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("fixed_object_pool_allocator test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_status, out_granted_index, out_free_objects, out_used_objects);
  end

  task automatic issue(op_t op, logic [IDX_W-1:0] idx, int idle_pct);
    int gap;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_op <= op;
    in_object_index <= idx;
    do @(posedge clk); while (busy);
    sb.note_request(op, idx);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending_answers.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_count(logic [CNT_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_object_count <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.rebuild(value);
    sizes_tried++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(logic [CNT_W-1:0] count, int items, int idle_pct);
    int bias;
    int roll;
    int pick;
    write_count(count);
    bias = 50;
    for (int i = 0; i < items; i++) begin
      if (i % 32 == 0) bias = ($urandom_range(0, 2) == 0) ? 20 :
                              ($urandom_range(0, 1) == 0) ? 50 : 80;
      if (i == items / 2) drain();
      roll = $urandom_range(0, 99);
      pick = sb.pick_held();
      if (roll < bias)
        issue(OP_ALLOC, IDX_W'($urandom_range(0, POOL_DEPTH - 1)), idle_pct);
      else if (roll < 92 && pick >= 0)
        issue(OP_FREE, IDX_W'(pick), idle_pct);
      else
        issue(OP_FREE, IDX_W'($urandom_range(0, POOL_DEPTH - 1)), idle_pct);
    end
  endtask

  initial begin
    logic [CNT_W-1:0] counts [8];
    sb = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset pool of 64: highest index first, then double and stray frees.
    issue(OP_ALLOC, 6'd0, 0);
    issue(OP_ALLOC, 6'd63, 0);
    issue(OP_FREE, 6'd63, 0);
    issue(OP_FREE, 6'd63, 0);
    issue(OP_FREE, 6'd0, 0);
    issue(OP_FREE, 6'd62, 0);
    // A single object: empty pool and out-of-range frees.
    write_count(7'd1);
    issue(OP_ALLOC, 6'd0, 0);
    issue(OP_ALLOC, 6'd0, 0);
    issue(OP_FREE, 6'd1, 0);
    issue(OP_FREE, 6'd0, 0);
    issue(OP_FREE, 6'd63, 0);
    // An empty pool answers empty and invalid throughout.
    write_count(7'd0);
    issue(OP_ALLOC, 6'd0, 0);
    issue(OP_FREE, 6'd0, 0);
    // A count beyond the pool is clamped to its depth.
    write_count(7'd127);
    issue(OP_ALLOC, 6'd63, 0);
    issue(OP_FREE, 6'd63, 0);
    write_count(7'd2);
    issue(OP_ALLOC, 6'd0, 0);
    issue(OP_ALLOC, 6'd0, 0);
    issue(OP_ALLOC, 6'd0, 0);
    issue(OP_FREE, 6'd1, 0);
    issue(OP_FREE, 6'd0, 0);

    counts = '{7'd64, 7'd3, 7'd1, 7'd127, 7'd17, 7'd0,
               CNT_W'($urandom_range(1, 64)), 7'd64};
    for (int p = 0; p < 8; p++) begin
      random_phase(counts[p], (counts[p] == 0) ? 40 : 235,
                   (p % 3 == 0) ? 0 : (p % 3 == 1) ? 50 : 33);
    end

    drain();
    $display("Covered %0d requests over %0d pool sizes, from empty and single-object pools",
             sb.requests, sizes_tried + 1);
    $display("to a clamped full pool: %0d grants, %0d empty answers, %0d rejected frees.",
             sb.grants, sb.empties, sb.rejects);
    if (sb.mismatches == 0 && sb.pending_answers.size() == 0) begin
      $display("fixed_object_pool_allocator test passed");
    end else begin
      $display("fixed_object_pool_allocator test failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/fopa_pkg.sv
rtl/fopa_stack.sv
rtl/fopa_mark.sv
rtl/fixed_object_pool_allocator.sv
tb/sv/fixed_object_pool_allocator_test.sv
